@@ hdl/ider_pkg.sv @@
// Shared types, constants and helper functions of the inertial dead-reckoning block.
package ider_pkg;

   localparam int unsigned GravityWidth = 21;
   localparam logic [GravityWidth-1:0] GRAVITY_Y_RESET = 21'd642975;

   localparam logic signed [31:0] QUAT_MAX = 32'sd1073741824;
   localparam logic signed [31:0] QUAT_MIN = -32'sd1073741824;

   localparam logic signed [63:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] SAT_MIN = 64'sh8000_0000_0000_0000;

   // one classified sample: body acceleration, scalar part, negated vector part, time step
   typedef struct packed {
      logic [2:0][31:0] accel;
      logic [31:0]      qw;
      logic [2:0][31:0] u;
      logic [23:0]      dt;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

   // what a product in flight is used for when it comes back
   typedef enum logic [2:0] {
      K_CROSS = 3'd0,
      K_ROT   = 3'd1,
      K_SQ    = 3'd2,
      K_DV    = 3'd3,
      K_LO    = 3'd4,
      K_HI    = 3'd5
   } kind_type;

   typedef struct packed {
      logic     valid;
      kind_type kind;
      logic [1:0] axis;
      logic     sub;
   } pend_type;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_CROSS = 8'b0000_0010,
      S_ROT   = 8'b0000_0100,
      S_SQ    = 8'b0000_1000,
      S_ROOT  = 8'b0001_0000,
      S_DV    = 8'b0010_0000,
      S_INT   = 8'b0100_0000,
      S_DONE  = 8'b1000_0000
   } state_type;

   function automatic logic [1:0] next_axis(input logic [1:0] a);
      logic [1:0] r;
      case (a)
         2'd0:    r = 2'd1;
         2'd1:    r = 2'd2;
         default: r = 2'd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] s;
      logic signed [63:0] r;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         r = s[64] ? SAT_MIN : SAT_MAX;
      end else begin
         r = s[63:0];
      end
      return r;
   endfunction

endpackage

@@ hdl/ider_channels.sv @@
// Request and response channel interfaces of the inertial dead-reckoning block.
interface ider_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] accel_x;
   logic signed [31:0] accel_y;
   logic signed [31:0] accel_z;
   logic signed [31:0] quat_w;
   logic signed [31:0] quat_x;
   logic signed [31:0] quat_y;
   logic signed [31:0] quat_z;
   logic [23:0]        time_step;

   modport source(output valid, accel_x, accel_y, accel_z, quat_w, quat_x, quat_y, quat_z,
                  time_step, input ready);
   modport sink(input valid, accel_x, accel_y, accel_z, quat_w, quat_x, quat_y, quat_z,
                time_step, output ready);
endinterface

interface ider_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] vel_x;
   logic signed [63:0] vel_y;
   logic signed [63:0] vel_z;
   logic signed [63:0] pos_x;
   logic signed [63:0] pos_y;
   logic signed [63:0] pos_z;
   logic [31:0]        accel_magnitude;

   modport source(output valid, vel_x, vel_y, vel_z, pos_x, pos_y, pos_z, accel_magnitude,
                  input ready);
   modport sink(input valid, vel_x, vel_y, vel_z, pos_x, pos_y, pos_z, accel_magnitude,
                output ready);
endinterface

@@ hdl/imu_dead_reckoning_integrator_unit.sv @@
// Top level of the strapdown inertial dead-reckoning integrator.
//
// Each request transaction carries one inertial sample (body acceleration Q15.16,
// quaternion Q1.30, time step Q0.24) and yields exactly one response transaction
// with the updated world velocity and position (Q31.32, saturating per axis) and
// the world acceleration magnitude (Q16.16, saturating). A transaction occupies the
// back end through a load step, the cross product, the rotation, the sum of squares,
// the bit-per-cycle square root, the velocity update, the position update and a
// hand-off into the output register; these steps run one after another because of
// the single shared 37x35 multiplier that
// every product goes through, and because of the root unit. A two-entry queue in front and
// the output register behind let the requester and the consumer stall on their own.
// Gravity (csr_wr_data, Q5.16 along world y) is written on csr_wr_en; write it
// only while no transaction is in flight.
module imu_dead_reckoning_integrator_unit (
   input  logic                              clock,
   input  logic                              reset,
   ider_req_if.sink                          req_if,
   ider_rsp_if.source                        rsp_if,
   input  logic                              csr_wr_en,
   input  logic [ider_pkg::GravityWidth-1:0] csr_wr_data
);

   // queue head from the front end and the pop strobe from the back end
   ider_pkg::queue_head_type head;
   logic                     pop;

   // front end: clamp the quaternion, negate its vector part, queue the sample
   ider_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .pop    (pop),
      .head   (head)
   );

   // back end: rotate, measure, integrate, and advance the stored state
   ider_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .pop         (pop),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_if      (rsp_if)
   );

endmodule

@@ hdl/ider_front.sv @@
// Front end: accept samples, clamp and conjugate the quaternion, hold them in a two-entry queue.
module ider_front (
   input  logic                    clock,
   input  logic                    reset,
   ider_req_if.sink                req_if,
   input  logic                    pop,
   output ider_pkg::queue_head_type head
);

   ider_pkg::item_type mem_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         cnt_ff, cnt_in;
   ider_pkg::item_type item;
   logic               push;

   function automatic logic [31:0] clamp_q(input logic signed [31:0] x);
      logic signed [31:0] r;
      if (x > ider_pkg::QUAT_MAX) begin
         r = ider_pkg::QUAT_MAX;
      end else if (x < ider_pkg::QUAT_MIN) begin
         r = ider_pkg::QUAT_MIN;
      end else begin
         r = x;
      end
      return r;
   endfunction

   always_comb begin
      item.accel[0] = req_if.accel_x;
      item.accel[1] = req_if.accel_y;
      item.accel[2] = req_if.accel_z;
      item.qw       = clamp_q(req_if.quat_w);
      item.u[0]     = -clamp_q(req_if.quat_x);
      item.u[1]     = -clamp_q(req_if.quat_y);
      item.u[2]     = -clamp_q(req_if.quat_z);
      item.dt       = req_if.time_step;
   end

   assign req_if.ready = (cnt_ff != 2'd2);
   assign push         = req_if.valid && req_if.ready;
   assign head.valid   = (cnt_ff != 2'd0);
   assign head.item    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

@@ hdl/ider_back.sv @@
// Back end: sequence one shared multiplier and a root unit through rotation and integration.
module ider_back (
   input  logic                           clock,
   input  logic                           reset,
   input  ider_pkg::queue_head_type       head,
   output logic                           pop,
   input  logic                           csr_wr_en,
   input  logic [ider_pkg::GravityWidth-1:0] csr_wr_data,
   ider_rsp_if.source                     rsp_if
);

   ider_pkg::state_type state_ff, state_in;
   logic [4:0]          idx_ff, idx_in;
   ider_pkg::pend_type  pend_ff, pend_in;
   logic signed [71:0]  p_ff, p_in;
   logic signed [36:0]  mul_a;
   logic signed [34:0]  mul_b;

   logic [ider_pkg::GravityWidth-1:0] grav_ff;

   logic signed [31:0] v_ff [3], v_in [3];
   logic signed [31:0] u_ff [3], u_in [3];
   logic signed [31:0] qw_ff, qw_in;
   logic [23:0]        dt_ff, dt_in;
   logic signed [33:0] c_ff [3], c_in [3];
   logic signed [36:0] w_ff [3], w_in [3];
   logic [63:0]        op_ff, op_in;
   logic [63:0]        res_ff, res_in;
   logic [63:0]        one_ff, one_in;
   logic               sat_ff, sat_in;
   logic [31:0]        mag_ff, mag_in;
   logic [56:0]        tmp_ff, tmp_in;
   logic signed [63:0] vel_ff [3], vel_in [3];
   logic signed [63:0] pos_ff [3], pos_in [3];

   logic signed [63:0] ovel_ff [3], ovel_in [3];
   logic signed [63:0] opos_ff [3], opos_in [3];
   logic [31:0]        omag_ff, omag_in;
   logic               ovalid_ff, ovalid_in;

   logic [1:0]         ax, aj, ak;
   logic signed [36:0] absw;
   logic [64:0]        sqsum;
   logic [63:0]        trial;
   logic signed [89:0] hsum;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      pend_in  = '0;
      mul_a    = '0;
      mul_b    = '0;
      v_in     = v_ff;
      u_in     = u_ff;
      qw_in    = qw_ff;
      dt_in    = dt_ff;
      c_in     = c_ff;
      w_in     = w_ff;
      op_in    = op_ff;
      res_in   = res_ff;
      one_in   = one_ff;
      sat_in   = sat_ff;
      mag_in   = mag_ff;
      tmp_in   = tmp_ff;
      vel_in   = vel_ff;
      pos_in   = pos_ff;
      ovel_in  = ovel_ff;
      opos_in  = opos_ff;
      omag_in  = omag_ff;
      ovalid_in = ovalid_ff && !rsp_if.ready;
      pop      = 1'b0;
      ax       = 2'd0;
      aj       = 2'd0;
      ak       = 2'd0;
      absw     = '0;
      sqsum    = '0;
      trial    = '0;
      hsum     = '0;

      // retire the product issued last cycle
      if (pend_ff.valid) begin
         case (pend_ff.kind)
            ider_pkg::K_CROSS: begin
               if (pend_ff.sub) begin
                  c_in[pend_ff.axis] = c_ff[pend_ff.axis] - p_ff[63:30];
               end else begin
                  c_in[pend_ff.axis] = c_ff[pend_ff.axis] + p_ff[63:30];
               end
            end
            ider_pkg::K_ROT: begin
               if (pend_ff.sub) begin
                  w_in[pend_ff.axis] = w_ff[pend_ff.axis] - p_ff[65:29];
               end else begin
                  w_in[pend_ff.axis] = w_ff[pend_ff.axis] + p_ff[65:29];
               end
            end
            ider_pkg::K_SQ: begin
               sqsum = {1'b0, op_ff} + {1'b0, p_ff[63:0]};
               op_in = sqsum[63:0];
               if (sqsum[64]) begin
                  sat_in = 1'b1;
               end
            end
            ider_pkg::K_DV: begin
               vel_in[pend_ff.axis] = ider_pkg::sat_add(vel_ff[pend_ff.axis], p_ff[71:8]);
            end
            ider_pkg::K_LO: begin
               tmp_in = p_ff[56:0];
            end
            ider_pkg::K_HI: begin
               hsum = {p_ff[57:0], 32'd0} + {33'd0, tmp_ff};
               pos_in[pend_ff.axis] = ider_pkg::sat_add(pos_ff[pend_ff.axis], hsum[87:24]);
            end
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         ider_pkg::S_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               for (int i = 0; i < 3; i++) begin
                  v_in[i] = head.item.accel[i];
                  u_in[i] = head.item.u[i];
                  c_in[i] = '0;
                  w_in[i] = {{5{head.item.accel[i][31]}}, head.item.accel[i]};
               end
               qw_in    = head.item.qw;
               dt_in    = head.item.dt;
               op_in    = '0;
               res_in   = '0;
               one_in   = 64'd1 << 62;
               sat_in   = 1'b0;
               idx_in   = 5'd0;
               state_in = ider_pkg::S_CROSS;
            end
         end
         ider_pkg::S_CROSS: begin
            // c = u x v, two products per axis
            ax = idx_ff[2:1];
            aj = ider_pkg::next_axis(ax);
            ak = ider_pkg::next_axis(aj);
            if (idx_ff == 5'd6) begin
               idx_in   = 5'd0;
               state_in = ider_pkg::S_ROT;
            end else begin
               if (idx_ff[0]) begin
                  mul_a = {{5{u_ff[ak][31]}}, u_ff[ak]};
                  mul_b = {{3{v_ff[aj][31]}}, v_ff[aj]};
               end else begin
                  mul_a = {{5{u_ff[aj][31]}}, u_ff[aj]};
                  mul_b = {{3{v_ff[ak][31]}}, v_ff[ak]};
               end
               pend_in = '{valid: 1'b1, kind: ider_pkg::K_CROSS, axis: ax, sub: idx_ff[0]};
               idx_in  = idx_ff + 5'd1;
            end
         end
         ider_pkg::S_ROT: begin
            // w = v + 2 qw c + 2 u x c, three products per axis
            case (idx_ff)
               5'd0, 5'd1, 5'd2: ax = 2'd0;
               5'd3, 5'd4, 5'd5: ax = 2'd1;
               default:          ax = 2'd2;
            endcase
            aj = ider_pkg::next_axis(ax);
            ak = ider_pkg::next_axis(aj);
            if (idx_ff == 5'd9) begin
               idx_in   = 5'd0;
               state_in = ider_pkg::S_SQ;
            end else begin
               pend_in = '{valid: 1'b1, kind: ider_pkg::K_ROT, axis: ax, sub: 1'b0};
               case (idx_ff)
                  5'd0, 5'd3, 5'd6: begin
                     mul_a = {{3{c_ff[ax][33]}}, c_ff[ax]};
                     mul_b = {{3{qw_ff[31]}}, qw_ff};
                  end
                  5'd1, 5'd4, 5'd7: begin
                     mul_a = {{3{c_ff[ak][33]}}, c_ff[ak]};
                     mul_b = {{3{u_ff[aj][31]}}, u_ff[aj]};
                  end
                  default: begin
                     mul_a = {{3{c_ff[aj][33]}}, c_ff[aj]};
                     mul_b = {{3{u_ff[ak][31]}}, u_ff[ak]};
                     pend_in.sub = 1'b1;
                  end
               endcase
               idx_in = idx_ff + 5'd1;
            end
         end
         ider_pkg::S_SQ: begin
            // sum of squares for the magnitude; drop to saturation on a wide axis; then subtract gravity from y
            if (idx_ff == 5'd3) begin
               w_in[1]  = w_ff[1] - {16'd0, grav_ff};
               idx_in   = 5'd0;
               state_in = ider_pkg::S_ROOT;
            end else begin
               ax   = idx_ff[1:0];
               absw = w_ff[ax][36] ? -w_ff[ax] : w_ff[ax];
               if (absw[36:32] != 5'd0) begin
                  sat_in = 1'b1;
               end
               mul_a   = {5'd0, absw[31:0]};
               mul_b   = {3'd0, absw[31:0]};
               pend_in = '{valid: 1'b1, kind: ider_pkg::K_SQ, axis: ax, sub: 1'b0};
               idx_in  = idx_ff + 5'd1;
            end
         end
         ider_pkg::S_ROOT: begin
            // one result bit per cycle, restoring square root
            trial = res_ff + one_ff;
            if (op_ff >= trial) begin
               op_in  = op_ff - trial;
               res_in = (res_ff >> 1) + one_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            one_in = one_ff >> 2;
            if (idx_ff == 5'd31) begin
               idx_in   = 5'd0;
               state_in = ider_pkg::S_DV;
            end else begin
               idx_in = idx_ff + 5'd1;
            end
         end
         ider_pkg::S_DV: begin
            ax = idx_ff[1:0];
            if (idx_ff == 5'd0) begin
               mag_in = sat_ff ? 32'hFFFF_FFFF : res_ff[31:0];
            end
            mul_a   = w_ff[ax];
            mul_b   = {11'd0, dt_ff};
            pend_in = '{valid: 1'b1, kind: ider_pkg::K_DV, axis: ax, sub: 1'b0};
            if (idx_ff == 5'd2) begin
               idx_in   = 5'd0;
               state_in = ider_pkg::S_INT;
            end else begin
               idx_in = idx_ff + 5'd1;
            end
         end
         ider_pkg::S_INT: begin
            // velocity * dt in two partial products: low word, then signed high word
            ax = idx_ff[2:1];
            if (idx_ff == 5'd6) begin
               idx_in   = 5'd0;
               state_in = ider_pkg::S_DONE;
            end else begin
               mul_b = {11'd0, dt_ff};
               if (idx_ff[0]) begin
                  mul_a   = {{5{vel_ff[ax][63]}}, vel_ff[ax][63:32]};
                  pend_in = '{valid: 1'b1, kind: ider_pkg::K_HI, axis: ax, sub: 1'b0};
               end else begin
                  mul_a   = {5'd0, vel_ff[ax][31:0]};
                  pend_in = '{valid: 1'b1, kind: ider_pkg::K_LO, axis: ax, sub: 1'b0};
               end
               idx_in = idx_ff + 5'd1;
            end
         end
         ider_pkg::S_DONE: begin
            // hold until the output register is free
            if (!ovalid_ff || rsp_if.ready) begin
               ovel_in   = vel_ff;
               opos_in   = pos_ff;
               omag_in   = mag_ff;
               ovalid_in = 1'b1;
               state_in  = ider_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ider_pkg::S_IDLE;
         end
      endcase
   end

   assign p_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ider_pkg::S_IDLE;
         idx_ff    <= 5'd0;
         pend_ff   <= '0;
         grav_ff   <= ider_pkg::GRAVITY_Y_RESET;
         ovalid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            vel_ff[i] <= '0;
            pos_ff[i] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         idx_ff    <= idx_in;
         pend_ff   <= pend_in;
         ovalid_ff <= ovalid_in;
         vel_ff    <= vel_in;
         pos_ff    <= pos_in;
         if (csr_wr_en) begin
            grav_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      p_ff    <= p_in;
      v_ff    <= v_in;
      u_ff    <= u_in;
      qw_ff   <= qw_in;
      dt_ff   <= dt_in;
      c_ff    <= c_in;
      w_ff    <= w_in;
      op_ff   <= op_in;
      res_ff  <= res_in;
      one_ff  <= one_in;
      sat_ff  <= sat_in;
      mag_ff  <= mag_in;
      tmp_ff  <= tmp_in;
      ovel_ff <= ovel_in;
      opos_ff <= opos_in;
      omag_ff <= omag_in;
   end

   assign rsp_if.valid           = ovalid_ff;
   assign rsp_if.vel_x           = ovel_ff[0];
   assign rsp_if.vel_y           = ovel_ff[1];
   assign rsp_if.vel_z           = ovel_ff[2];
   assign rsp_if.pos_x           = opos_ff[0];
   assign rsp_if.pos_y           = opos_ff[1];
   assign rsp_if.pos_z           = opos_ff[2];
   assign rsp_if.accel_magnitude = omag_ff;

endmodule
